// ----- rtl/tcw_pkg.sv -----
// Shared constants, types and codes for the text console writer.
// No dependencies; the interfaces, the cursor unit, the top level and the testbench use this package.
package tcw_pkg;

   // Screen geometry.
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   // Field widths of the channels and the configuration port.
   localparam int MODE_W     = 1;
   localparam int CHAR_W     = 8;
   localparam int IDX_W      = 11;
   localparam int POS_W      = 11;
   localparam int CELL_W     = 16;
   localparam int COLOUR_W   = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   // Internal widths derived from the geometry.
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS + 1);
   localparam int PF_W   = ROW_W + COL_W + 1;
   localparam int SUM_W  = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

   // Division of a cell index by COLUMNS as a multiply by a rounded-up
   // reciprocal; the shift is wide enough that the quotient is exact.
   localparam int DIV_SHIFT  = IDX_W + COL_W + 1;
   localparam int DIV_MULT   = ((2 ** DIV_SHIFT) + COLUMNS - 1) / COLUMNS;
   localparam int DIV_PROD_W = IDX_W + DIV_SHIFT;

   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

   localparam logic [MODE_W-1:0] MODE_PUT  = 1'b0;
   localparam logic [MODE_W-1:0] MODE_READ = 1'b1;

   localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;

   localparam logic [CSR_IDX_W-1:0] CSR_FG = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG = 1'b1;

   localparam logic [COLOUR_W-1:0] FG_RESET = 4'h0;
   localparam logic [COLOUR_W-1:0] BG_RESET = 4'h7;

   // Source of the data returned in a word.
   localparam logic [1:0] KIND_ZERO  = 2'd0;
   localparam logic [1:0] KIND_BLANK = 2'd1;
   localparam logic [1:0] KIND_MEM   = 2'd2;

   typedef logic [1:0] kind_type;

   // Per-item decisions from the cursor unit to the datapath.
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      kind_type          kind;
      logic [POS_W-1:0]  pos;
      logic              scrolled;
   } step_type;

endpackage

// ----- rtl/tcw_req_if.sv -----
// Request channel of the text console writer: valid/ready and one item.
// Depends on tcw_pkg for the field widths.
interface tcw_req_if;
   logic                        valid;
   logic                        ready;
   logic [tcw_pkg::MODE_W-1:0]  mode;
   logic [tcw_pkg::CHAR_W-1:0]  char_code;
   logic [tcw_pkg::IDX_W-1:0]   cell_index;

   modport source (output valid, mode, char_code, cell_index, input ready);
   modport sink   (input valid, mode, char_code, cell_index, output ready);
endinterface

// ----- rtl/tcw_rsp_if.sv -----
// Response channel of the text console writer: valid/ready and one result.
// Depends on tcw_pkg for the field widths.
interface tcw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tcw_pkg::POS_W-1:0]   cursor_pos;
   logic [tcw_pkg::CELL_W-1:0]  cell_data;
   logic                        scrolled;

   modport source (output valid, cursor_pos, cell_data, scrolled, input ready);
   modport sink   (input valid, cursor_pos, cell_data, scrolled, output ready);
endinterface

// ----- rtl/tcw_screen_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds while no read is issued.
module tcw_screen_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/tcw_cursor.sv -----
// Cursor, circular row offset and per-row fill counts of the console.
// Maps each item onto screen RAM accesses. Depends on tcw_pkg.
module tcw_cursor (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [tcw_pkg::MODE_W-1:0]  mode,
   input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
   input  logic [tcw_pkg::IDX_W-1:0]   cell_index,
   output tcw_pkg::step_type           ctl
);
   import tcw_pkg::*;

   // The screen is a ring of physical rows; top_ff is the physical row
   // shown at the top, so a scroll only moves the ring. Cells written
   // since a row was last recycled always form a prefix of the row, so
   // one count per row tells which cells still read as blank.
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ROW_W-1:0]  phys_ff, phys_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [COL_W-1:0]  cur_fill_ff, cur_fill_in;
   logic [COL_W-1:0]  fill_ff [ROWS];

   logic              is_put, is_lf, is_cr, is_print;
   logic [COL_W-1:0]  col_inc, fill_upd;
   logic              wrap, row_move, at_bottom, scroll;
   logic [ROW_W-1:0]  phys_inc;
   logic [PF_W-1:0]   pos_full;
   logic [PF_W-1:0]   wr_full;

   logic [DIV_PROD_W-1:0] quot_prod;
   logic [ROW_W-1:0]      q_row;
   logic [IDX_W-1:0]      q_rem;
   logic [COL_W-1:0]      q_col;
   logic [ROW_W:0]        q_phys_sum;
   logic [ROW_W-1:0]      q_phys;
   logic [COL_W-1:0]      q_fill;
   logic [SUM_W-1:0]      rd_sum;
   logic                  idx_oob;

   always_comb begin
      is_put    = step && (mode == MODE_PUT);
      is_lf     = char_code == CHAR_LF;
      is_cr     = char_code == CHAR_CR;
      is_print  = is_put && !is_lf && !is_cr;
      col_inc   = col_ff + COL_W'(1);
      fill_upd  = (is_print && (col_ff == cur_fill_ff)) ? col_inc : cur_fill_ff;
      wrap      = is_print && (col_inc == COL_W'(COLUMNS));
      row_move  = is_put && (is_lf || wrap);
      at_bottom = row_ff == ROW_W'(ROWS - 1);
      scroll    = row_move && at_bottom;
      phys_inc  = (phys_ff == ROW_W'(ROWS - 1)) ? '0 : phys_ff + ROW_W'(1);

      col_in = col_ff;
      if (is_put && (is_lf || is_cr || wrap)) begin
         col_in = '0;
      end else if (is_print) begin
         col_in = col_inc;
      end

      row_in      = (row_move && !at_bottom) ? row_ff + ROW_W'(1) : row_ff;
      phys_in     = row_move ? (at_bottom ? top_ff : phys_inc) : phys_ff;
      top_in      = top_ff;
      base_in     = base_ff;
      if (scroll) begin
         top_in  = (top_ff == ROW_W'(ROWS - 1)) ? '0 : top_ff + ROW_W'(1);
         base_in = (base_ff == ADDR_W'((ROWS - 1) * COLUMNS)) ? '0
                   : base_ff + ADDR_W'(COLUMNS);
      end
      cur_fill_in = row_move ? '0 : (is_put ? fill_upd : cur_fill_ff);
   end

   // Read address split into row and column for the fill check.
   always_comb begin
      idx_oob    = cell_index >= IDX_W'(CELLS);
      quot_prod  = DIV_PROD_W'(cell_index) * DIV_PROD_W'(DIV_MULT);
      q_row      = quot_prod[DIV_SHIFT +: ROW_W];
      q_rem      = cell_index - IDX_W'(q_row) * IDX_W'(COLUMNS);
      q_col      = q_rem[COL_W-1:0];
      q_phys_sum = {1'b0, q_row} + {1'b0, top_ff};
      q_phys     = (q_phys_sum >= (ROW_W + 1)'(ROWS))
                   ? ROW_W'(q_phys_sum - (ROW_W + 1)'(ROWS)) : q_phys_sum[ROW_W-1:0];
      q_fill     = (q_phys == phys_ff) ? cur_fill_ff : fill_ff[q_phys];
      rd_sum     = SUM_W'(cell_index) + SUM_W'(base_ff);
      if (rd_sum >= SUM_W'(CELLS)) begin
         rd_sum = rd_sum - SUM_W'(CELLS);
      end
   end

   always_comb begin
      pos_full = PF_W'(row_in) * PF_W'(COLUMNS) + PF_W'(col_in);
      wr_full  = PF_W'(phys_ff) * PF_W'(COLUMNS) + PF_W'(col_ff);

      ctl.wr_en    = is_print;
      ctl.wr_addr  = wr_full[ADDR_W-1:0];
      ctl.rd_en    = step && (mode == MODE_READ) && !idx_oob && (q_col < q_fill);
      ctl.rd_addr  = rd_sum[ADDR_W-1:0];
      ctl.pos      = pos_full[POS_W-1:0];
      ctl.scrolled = scroll;
      if (mode == MODE_PUT || idx_oob) begin
         ctl.kind = KIND_ZERO;
      end else if (q_col < q_fill) begin
         ctl.kind = KIND_MEM;
      end else begin
         ctl.kind = KIND_BLANK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         phys_ff     <= '0;
         top_ff      <= '0;
         base_ff     <= '0;
         cur_fill_ff <= '0;
         for (int i = 0; i < ROWS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         phys_ff     <= phys_in;
         top_ff      <= top_in;
         base_ff     <= base_in;
         cur_fill_ff <= cur_fill_in;
         // The row being left keeps its count in the array; the cursor
         // row itself always uses cur_fill_ff.
         if (row_move) begin
            fill_ff[phys_ff] <= fill_upd;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff < COL_W'(COLUMNS))
      else $error("cursor column beyond the last column");

   a_fill_covers_cursor: assert property (@(posedge clock) disable iff (reset)
      cur_fill_ff >= col_ff)
      else $error("cursor row fill count behind the cursor");

   a_scroll_bottom: assert property (@(posedge clock) disable iff (reset)
      scroll |=> (row_ff == ROW_W'(ROWS - 1)) && (col_ff == '0) && (phys_ff == $past(top_ff)))
      else $error("scroll did not leave the cursor at the start of the bottom row");

   a_base_matches_top: assert property (@(posedge clock) disable iff (reset)
      base_ff == ADDR_W'(PF_W'(top_ff) * PF_W'(COLUMNS)))
      else $error("ring base address out of step with the top row");
`endif
endmodule

// ----- rtl/text_console_writer.sv -----
// Top level of the text console writer: colour registers, request stage,
// output register and the screen RAM. Depends on tcw_pkg, tcw_req_if,
// tcw_rsp_if, tcw_cursor and tcw_screen_ram.
//
//   Channel   Direction  Handshake            Carries
//   req_chan  in         valid/ready          mode, char_code, cell_index
//   rsp_chan  out        valid/ready          cursor_pos, cell_data, scrolled
//   csr_*     in         csr_wr_en, no wait   fg/bg colour nibbles
//
// One item is taken per cycle while the output is not stalled; its word is held in
// the request stage, beside the registered read of the screen RAM, then in the output register.
// Scrolling moves a ring offset over the RAM rows and does not stall the channel.
// Reset is synchronous and needs no clearing pass: per-row fill counts make
// cells not yet written read as blank.
// While the output word is stalled, one more item is held in the request
// stage and the channel then stops taking items.
module text_console_writer (
   input  logic                           clock,
   input  logic                           reset,
   tcw_req_if.sink                        req_chan,
   tcw_rsp_if.source                      rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import tcw_pkg::*;

   logic [COLOUR_W-1:0] fg_ff, bg_ff;

   logic              accept, out_free, s1_move;
   step_type          ctl;
   logic [CELL_W-1:0] ram_rd_data;
   logic [CELL_W-1:0] wr_word;
   logic [CELL_W-1:0] s1_data;

   logic              s1_valid_ff, s1_valid_in;
   kind_type          s1_kind_ff;
   logic [POS_W-1:0]  s1_pos_ff;
   logic              s1_scrolled_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic [CELL_W-1:0] rsp_data_ff;
   logic              rsp_scrolled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FG_RESET;
         bg_ff <= BG_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FG: fg_ff <= csr_wr_data[COLOUR_W-1:0];
            CSR_BG: bg_ff <= csr_wr_data[COLOUR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_move        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign accept         = req_chan.valid && req_chan.ready;

   tcw_cursor u_cursor (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .mode       (req_chan.mode),
      .char_code  (req_chan.char_code),
      .cell_index (req_chan.cell_index),
      .ctl        (ctl)
   );

   assign wr_word = {fg_ff, bg_ff, req_chan.char_code};

   tcw_screen_ram #(
      .DATA_W (CELL_W),
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (ctl.wr_addr),
      .wr_data (wr_word),
      .rd_en   (ctl.rd_en),
      .rd_addr (ctl.rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_move ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
      case (s1_kind_ff)
         KIND_MEM:   s1_data = ram_rd_data;
         KIND_BLANK: s1_data = BLANK_CELL;
         default:    s1_data = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff     <= ctl.kind;
         s1_pos_ff      <= ctl.pos;
         s1_scrolled_ff <= ctl.scrolled;
      end
      if (s1_move) begin
         rsp_pos_ff      <= s1_pos_ff;
         rsp_data_ff     <= s1_data;
         rsp_scrolled_ff <= s1_scrolled_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.cursor_pos = rsp_pos_ff;
   assign rsp_chan.cell_data  = rsp_data_ff;
   assign rsp_chan.scrolled   = rsp_scrolled_ff;

`ifndef NO_ASSERTIONS
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> s1_valid_ff && $stable(s1_pos_ff))
      else $error("request stage word lost while the output is stalled");

   a_zero_on_put: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.mode == MODE_PUT) |=> s1_kind_ff == KIND_ZERO)
      else $error("put item classified as a read");

   a_ram_data_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_kind_ff == KIND_MEM && !out_free) |=> $stable(ram_rd_data))
      else $error("RAM read data changed under a stalled read word");
`endif
endmodule

// ----- verif/tb_text_console_writer.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for text_console_writer: puts and reads with
// random pacing, checked word by word against a cycle-free screen predictor.
// Depends on tcw_pkg, tcw_req_if, tcw_rsp_if and the block's RTL.
module tb_text_console_writer;
   import tcw_pkg::*;

   localparam int ITEMS_PER_PHASE = 388;
   localparam int PHASES          = 5;
   localparam int CYCLE_LIMIT     = 500000;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_pos;
      logic [CELL_W-1:0] cell_data;
      logic              scrolled;
   } console_word_type;

   // Screen predictor plus the store of words still owed by the block.
   class console_scoreboard;
      logic [CELL_W-1:0]   screen [CELLS];
      logic [COLOUR_W-1:0] fg;
      logic [COLOUR_W-1:0] bg;
      int unsigned         col;
      int unsigned         row;
      console_word_type    owed_words [$];
      int                  errors;

      function new();
         foreach (screen[k]) screen[k] = BLANK_CELL;
         fg     = FG_RESET;
         bg     = BG_RESET;
         col    = 0;
         row    = 0;
         errors = 0;
      endfunction

      function int pending();
         return owed_words.size();
      endfunction

      function int unsigned cursor_index();
         return row * COLUMNS + col;
      endfunction

      function void note_request(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] ch,
                                 logic [IDX_W-1:0] idx);
         console_word_type w;
         int unsigned      addr;
         w = '0;
         if (mode == MODE_READ) begin
            if (idx < CELLS) w.cell_data = screen[idx];
         end else begin
            if (ch == CHAR_LF) begin
               col = 0;
               row++;
            end else if (ch == CHAR_CR) begin
               col = 0;
            end else begin
               addr = row * COLUMNS + col;
               if (addr < CELLS) screen[addr] = {fg, bg, ch};
               col++;
               if (col >= COLUMNS) begin
                  col = 0;
                  row++;
               end
            end
            if (row >= ROWS) begin
               // Scroll up one row; the new bottom row is blank whatever the colours.
               for (int k = 0; k < CELLS - COLUMNS; k++) screen[k] = screen[k + COLUMNS];
               for (int k = CELLS - COLUMNS; k < CELLS; k++) screen[k] = BLANK_CELL;
               row        = ROWS - 1;
               w.scrolled = 1'b1;
            end
         end
         w.cursor_pos = POS_W'(row * COLUMNS + col);
         owed_words.push_back(w);
      endfunction

      function void check_word(console_word_type got);
         console_word_type want;
         if (owed_words.size() == 0) begin
            $error("word with nothing owed: cursor_pos %0d cell_data 0x%04h scrolled %0d",
                   got.cursor_pos, got.cell_data, got.scrolled);
            errors++;
            return;
         end
         want = owed_words.pop_front();
         if (got.cursor_pos !== want.cursor_pos) begin
            $error("cursor_pos expected %0d got %0d", want.cursor_pos, got.cursor_pos);
            errors++;
         end
         if (got.cell_data !== want.cell_data) begin
            $error("cell_data expected 0x%04h got 0x%04h", want.cell_data, got.cell_data);
            errors++;
         end
         if (got.scrolled !== want.scrolled) begin
            $error("scrolled expected %0d got %0d", want.scrolled, got.scrolled);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   tcw_req_if req_chan ();
   tcw_rsp_if rsp_chan ();

   console_scoreboard sb;

   text_console_writer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog on the whole run.
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // Both handshakes are observed at the rising edge with pre-edge values.
   always @(posedge clock) begin
      if (!reset && sb != null) begin
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_word({rsp_chan.cursor_pos, rsp_chan.cell_data, rsp_chan.scrolled});
         if (req_chan.valid && req_chan.ready)
            sb.note_request(req_chan.mode, req_chan.char_code, req_chan.cell_index);
      end
   end

   // Receiver: runs of full speed, random stalls, a regular pattern and long holds.
   initial begin
      int style;
      int span;
      rsp_chan.ready = 1'b0;
      forever begin
         style = $urandom_range(0, 3);
         span  = $urandom_range(8, 64);
         for (int k = 0; k < span; k++) begin
            @(negedge clock);
            case (style)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= 1'($urandom_range(0, 1));
               2: rsp_chan.ready <= (k % 3 != 0);
               default: rsp_chan.ready <= (k >= span - 2);
            endcase
         end
      end
   end

   task automatic send_item(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] ch,
                            logic [IDX_W-1:0] idx);
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.mode       <= mode;
      req_chan.char_code  <= ch;
      req_chan.cell_index <= idx;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic idle_gap(int cycles);
      @(negedge clock);
      req_chan.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Stop sending and wait until every owed word has come back.
   task automatic settle_idle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_colours(logic [COLOUR_W-1:0] fg, logic [COLOUR_W-1:0] bg);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_FG;
      csr_wr_data <= fg;
      @(negedge clock);
      csr_index   <= CSR_BG;
      csr_wr_data <= bg;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.fg = fg;
      sb.bg = bg;
   endtask

   task automatic send_random(int lf_pct);
      int               r;
      int unsigned      here;
      logic [CHAR_W-1:0] ch;
      logic [IDX_W-1:0]  idx;
      if ($urandom_range(0, 3) == 0) begin
         r    = $urandom_range(0, 99);
         here = sb.cursor_index();
         if (r < 15)      idx = IDX_W'($urandom_range(CELLS, 2 ** IDX_W - 1));
         else if (r < 25) idx = IDX_W'($urandom_range(CELLS - COLUMNS, CELLS - 1));
         else if (r < 55) idx = IDX_W'((here >= 4) ? here - $urandom_range(1, 4) : here);
         else             idx = IDX_W'($urandom_range(0, CELLS - 1));
         send_item(MODE_READ, CHAR_W'($urandom_range(0, 255)), idx);
      end else begin
         r = $urandom_range(0, 99);
         if (r < lf_pct)          ch = CHAR_LF;
         else if (r < lf_pct + 4) ch = CHAR_CR;
         else if (r < lf_pct + 8) ch = CHAR_W'($urandom_range(0, 31));
         else                     ch = CHAR_W'($urandom_range(0, 255));
         send_item(MODE_PUT, ch, IDX_W'($urandom_range(0, 2 ** IDX_W - 1)));
      end
   endtask

   initial begin
      logic [COLOUR_W-1:0] fg_set [PHASES];
      logic [COLOUR_W-1:0] bg_set [PHASES];
      int sent;
      int burst;
      int gap;
      int lf_pct;

      fg_set = '{4'h0, 4'hF, 4'h0, 4'hF, 4'h9};
      bg_set = '{4'h7, 4'h0, 4'hF, 4'hF, 4'h4};
      sb = new();

      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = CSR_FG;
      csr_wr_data         = '0;
      req_chan.valid      = 1'b0;
      req_chan.mode       = MODE_PUT;
      req_chan.char_code  = '0;
      req_chan.cell_index = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: blank store after reset, reads past the screen, byte zero,
      // all-ones bytes, control bytes, carriage return and newline.
      send_item(MODE_READ, 8'hFF, 11'd0);
      send_item(MODE_READ, 8'h00, IDX_W'(CELLS - 1));
      send_item(MODE_READ, 8'h00, IDX_W'(CELLS));
      send_item(MODE_READ, 8'h00, 11'h7FF);
      send_item(MODE_PUT, 8'h00, 11'h7FF);
      send_item(MODE_PUT, 8'hFF, 11'd0);
      send_item(MODE_PUT, 8'h41, 11'h400);
      send_item(MODE_PUT, CHAR_CR, 11'd0);
      send_item(MODE_PUT, 8'h1B, 11'd0);
      send_item(MODE_READ, 8'h00, 11'd0);
      send_item(MODE_READ, 8'h00, 11'd1);
      send_item(MODE_READ, 8'h00, 11'd2);
      send_item(MODE_PUT, CHAR_LF, 11'd0);
      send_item(MODE_PUT, 8'h7E, 11'd0);
      send_item(MODE_READ, 8'h00, IDX_W'(COLUMNS));
      send_item(MODE_READ, 8'h00, 11'h400);

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            settle_idle();
            write_colours(fg_set[p], bg_set[p]);
         end
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            burst = $urandom_range(1, 48);
            case ($urandom_range(0, 2))
               0: lf_pct = 0;
               1: lf_pct = 3;
               default: lf_pct = 15;
            endcase
            for (int b = 0; b < burst && sent < ITEMS_PER_PHASE; b++) begin
               send_random(lf_pct);
               sent++;
               if (p == 2 && sent == ITEMS_PER_PHASE / 2) settle_idle();
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) idle_gap(gap);
         end
      end

      settle_idle();
      repeat (6) @(posedge clock);
      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/tcw_pkg.sv
rtl/tcw_req_if.sv
rtl/tcw_rsp_if.sv
rtl/tcw_screen_ram.sv
rtl/tcw_cursor.sv
rtl/text_console_writer.sv
verif/tb_text_console_writer.sv
